// ===== rtl/core/pixel_replicating_upscaler_defines.svh =====
// Assertion macros used by the upscaler sequencer.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef PIXEL_REPLICATING_UPSCALER_DEFINES_SVH
`define PIXEL_REPLICATING_UPSCALER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pru assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pru assertion failed");

`endif

// ===== rtl/core/pru_pkg.sv =====
// Types and constants of the pixel replicating upscaler.
// Depends on nothing; used by the interfaces and all upscaler modules.
package pru_pkg;

  localparam int ADDR_BITS     = 26;
  localparam int PIX_PORT_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;
  localparam int MAX_RESULTS   = 64;
  localparam int RES_CNT_BITS  = $clog2(MAX_RESULTS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_H_FACTOR,
    REG_V_FACTOR,
    REG_H_GAP,
    REG_V_GAP
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE_MUL,
    ST_BASE,
    ST_EMIT,
    ST_SINGLE,
    ST_UPDATE
  } seq_state_e;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [10:0] src_width;
    logic [10:0] src_height;
    logic [3:0]  h_factor;
    logic [3:0]  v_factor;
    logic [2:0]  h_gap;
    logic [2:0]  v_gap;
  } cfg_raw_t;

  typedef struct packed {
    logic [PIX_PORT_BITS-1:0] src_pixel;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]     dest_address;
    logic [PIX_PORT_BITS-1:0] pixel_out;
    logic                     write_enable;
    logic                     factor_error;
    logic                     last_write;
  } out_item_t;

endpackage

// ===== rtl/core/pru_if.sv =====
// Valid/ready channel interfaces of the upscaler: source pixels, results, config.
// Depends on pru_pkg for the payload types.
interface pru_in_if;
  logic              valid;
  logic              ready;
  pru_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pru_out_if;
  logic               valid;
  logic               ready;
  pru_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pru_cfg_if;
  logic             valid;
  logic             ready;
  pru_pkg::cfg_wr_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/pru_cfg_regs.sv =====
// Configuration register file of the upscaler, written over the config channel.
// Depends on pru_pkg and pru_if.
module pru_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  pru_cfg_if.sink           cfg_i,
  output pru_pkg::cfg_raw_t cfg_o
);
  import pru_pkg::*;

  cfg_raw_t cfg_q;
  logic     wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;
  assign cfg_o       = cfg_q;

  // Indexes past the register list are accepted and dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width  <= 11'd320;
      cfg_q.src_height <= 11'd200;
      cfg_q.h_factor   <= 4'd2;
      cfg_q.v_factor   <= 4'd2;
      cfg_q.h_gap      <= 3'd0;
      cfg_q.v_gap      <= 3'd0;
    end else if (wr_en) begin
      case (cfg_reg_e'(cfg_i.payload.index))
        REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_i.payload.data[10:0];
        REG_SRC_HEIGHT: cfg_q.src_height <= cfg_i.payload.data[10:0];
        REG_H_FACTOR:   cfg_q.h_factor   <= cfg_i.payload.data[3:0];
        REG_V_FACTOR:   cfg_q.v_factor   <= cfg_i.payload.data[3:0];
        REG_H_GAP:      cfg_q.h_gap      <= cfg_i.payload.data[2:0];
        REG_V_GAP:      cfg_q.v_gap      <= cfg_i.payload.data[2:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pru_arith.sv =====
// Shared arithmetic unit: registered address-by-factor multiply, address adder.
// Depends on pru_pkg for the address width.
module pru_arith #(
  parameter int FACT_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          mul_en_i,
  input  logic [pru_pkg::ADDR_BITS-1:0] mul_a_i,
  input  logic [FACT_BITS-1:0]          mul_b_i,
  input  logic [pru_pkg::ADDR_BITS-1:0] add_a_i,
  input  logic [pru_pkg::ADDR_BITS-1:0] add_b_i,
  output logic [pru_pkg::ADDR_BITS-1:0] prod_o,
  output logic [pru_pkg::ADDR_BITS-1:0] sum_o
);
  import pru_pkg::*;

  logic [ADDR_BITS+FACT_BITS-1:0] prod_full;
  logic [ADDR_BITS-1:0]           prod_q;

  assign prod_full = mul_a_i * mul_b_i;

  // Addresses wrap modulo the framebuffer size.
  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_full[ADDR_BITS-1:0];
    end
  end

  assign prod_o = prod_q;
  assign sum_o  = add_a_i + add_b_i;

endmodule

// ===== rtl/core/pru_seq.sv =====
// Sequencer of the upscaler: source counters, block walk, result register.
// Depends on pru_pkg, pru_if and the assertion macro header.
`include "pixel_replicating_upscaler_defines.svh"

module pru_seq #(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024,
  parameter int MAX_FACTOR     = 8,
  parameter int PIXEL_BITS     = 32,
  parameter int FACT_BITS      = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pru_pkg::cfg_raw_t             cfg_raw_i,
  pru_in_if.sink                        src_i,
  pru_out_if.source                     res_o,
  output logic                          mul_en_o,
  output logic [pru_pkg::ADDR_BITS-1:0] mul_a_o,
  output logic [FACT_BITS-1:0]          mul_b_o,
  output logic [pru_pkg::ADDR_BITS-1:0] add_a_o,
  output logic [pru_pkg::ADDR_BITS-1:0] add_b_o,
  input  logic [pru_pkg::ADDR_BITS-1:0] prod_i,
  input  logic [pru_pkg::ADDR_BITS-1:0] sum_i
);
  import pru_pkg::*;

  localparam int W_BITS = $clog2(MAX_SRC_WIDTH + 1);
  localparam int H_BITS = $clog2(MAX_SRC_HEIGHT + 1);
  localparam int C_BITS = $clog2(MAX_SRC_WIDTH);
  localparam int R_BITS = $clog2(MAX_SRC_HEIGHT);

  seq_state_e state_q, state_d;

  logic [W_BITS-1:0]       w_eff;
  logic [H_BITS-1:0]       h_eff;
  logic [FACT_BITS-1:0]    hf, vf, kn, ln;
  logic                    err, gap;

  logic [C_BITS-1:0]       col_q;
  logic [R_BITS-1:0]       row_q;
  logic [ADDR_BITS-1:0]    row_base_q;
  logic [PIXEL_BITS-1:0]   pix_q;
  logic [ADDR_BITS-1:0]    pitch_q, cur_q, kaddr_q;
  logic [FACT_BITS-1:0]    k_q, l_q;
  logic [RES_CNT_BITS-1:0] n_q;
  logic                    k_last, l_last, item_last;

  logic                    out_valid_q, out_free, out_load;
  out_item_t               out_q, out_d;
  logic                    src_ready;

  // Effective sizes and factors: zero acts as one, oversize saturates.
  assign w_eff = (cfg_raw_i.src_width == '0) ? W_BITS'(1) :
                 (32'(cfg_raw_i.src_width) > 32'(MAX_SRC_WIDTH)) ? W_BITS'(MAX_SRC_WIDTH) :
                 W_BITS'(cfg_raw_i.src_width);
  assign h_eff = (cfg_raw_i.src_height == '0) ? H_BITS'(1) :
                 (32'(cfg_raw_i.src_height) > 32'(MAX_SRC_HEIGHT)) ? H_BITS'(MAX_SRC_HEIGHT) :
                 H_BITS'(cfg_raw_i.src_height);
  assign hf = (cfg_raw_i.h_factor == '0) ? FACT_BITS'(1) :
              (32'(cfg_raw_i.h_factor) > 32'(MAX_FACTOR)) ? FACT_BITS'(MAX_FACTOR) :
              FACT_BITS'(cfg_raw_i.h_factor);
  assign vf = (cfg_raw_i.v_factor == '0) ? FACT_BITS'(1) :
              (32'(cfg_raw_i.v_factor) > 32'(MAX_FACTOR)) ? FACT_BITS'(MAX_FACTOR) :
              FACT_BITS'(cfg_raw_i.v_factor);

  assign err = (hf == FACT_BITS'(1)) && (vf == FACT_BITS'(1));
  assign gap = (32'(cfg_raw_i.h_gap) >= 32'(hf)) || (32'(cfg_raw_i.v_gap) >= 32'(vf));
  assign kn  = FACT_BITS'(32'(hf) - 32'(cfg_raw_i.h_gap));
  assign ln  = FACT_BITS'(32'(vf) - 32'(cfg_raw_i.v_gap));

  assign k_last    = (k_q == FACT_BITS'(32'(kn) - 1));
  assign l_last    = (l_q == FACT_BITS'(32'(ln) - 1));
  assign item_last = (n_q == RES_CNT_BITS'(MAX_RESULTS - 1)) || (k_last && l_last);

  assign out_free = !out_valid_q || res_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (src_i.valid) state_d = ST_BASE_MUL;
      ST_BASE_MUL: state_d = ST_BASE;
      ST_BASE:     state_d = (err || gap) ? ST_SINGLE : ST_EMIT;
      ST_EMIT:     if (out_free && item_last) state_d = ST_UPDATE;
      ST_SINGLE:   if (out_free) state_d = ST_UPDATE;
      ST_UPDATE:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Unit operand selection and result formation.
  always_comb begin
    src_ready = 1'b0;
    mul_en_o  = 1'b0;
    mul_a_o   = '0;
    mul_b_o   = '0;
    add_a_o   = cur_q;
    add_b_o   = pitch_q;
    out_load  = 1'b0;
    out_d     = '0;
    case (state_q)
      ST_IDLE: begin
        src_ready = 1'b1;
        mul_en_o  = 1'b1;
        mul_a_o   = ADDR_BITS'(w_eff);
        mul_b_o   = hf;
      end
      ST_BASE_MUL: begin
        mul_en_o = 1'b1;
        mul_a_o  = ADDR_BITS'(col_q);
        mul_b_o  = hf;
      end
      ST_BASE: begin
        add_a_o  = row_base_q;
        add_b_o  = prod_i;
        mul_en_o = 1'b1;
        mul_a_o  = pitch_q;
        mul_b_o  = vf;
      end
      ST_EMIT: begin
        out_load           = out_free;
        out_d.dest_address = cur_q;
        out_d.pixel_out    = PIX_PORT_BITS'(pix_q);
        out_d.write_enable = 1'b1;
        out_d.last_write   = item_last;
        if (l_last) begin
          add_a_o = kaddr_q;
          add_b_o = ADDR_BITS'(1);
        end
      end
      ST_SINGLE: begin
        out_load           = out_free;
        out_d.factor_error = err;
        out_d.last_write   = 1'b1;
      end
      ST_UPDATE: begin
        add_a_o = row_base_q;
        add_b_o = prod_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance the source position once per pixel; wrap at the configured size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      row_base_q <= '0;
    end else if (state_q == ST_UPDATE) begin
      if (32'(col_q) + 1 >= 32'(w_eff)) begin
        col_q <= '0;
        if (32'(row_q) + 1 >= 32'(h_eff)) begin
          row_q      <= '0;
          row_base_q <= '0;
        end else begin
          row_q      <= R_BITS'(32'(row_q) + 1);
          row_base_q <= sum_i;
        end
      end else begin
        col_q <= C_BITS'(32'(col_q) + 1);
      end
    end
  end

  // Block walk: column offset outer, row offset inner.
  always_ff @(posedge clk_i) begin
    if (src_i.valid && src_ready) begin
      pix_q <= src_i.payload.src_pixel[PIXEL_BITS-1:0];
    end
    case (state_q)
      ST_BASE_MUL: pitch_q <= prod_i;
      ST_BASE: begin
        cur_q   <= sum_i;
        kaddr_q <= sum_i;
        k_q     <= '0;
        l_q     <= '0;
        n_q     <= '0;
      end
      ST_EMIT: begin
        if (out_free && !item_last) begin
          cur_q <= sum_i;
          n_q   <= n_q + 1'b1;
          if (l_last) begin
            kaddr_q <= sum_i;
            l_q     <= '0;
            k_q     <= k_q + 1'b1;
          end else begin
            l_q <= l_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Result register: hold while stalled, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign src_i.ready   = src_ready;
  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  `PRU_ASSERT_NEXT(a_accept_starts_setup, clk_i, rst_ni,
                   src_i.valid && src_ready, state_q == ST_BASE_MUL)
  `PRU_ASSERT_NEXT(a_last_ends_item, clk_i, rst_ni,
                   out_load && out_d.last_write, state_q == ST_UPDATE)
  `PRU_ASSERT_SAME(a_write_not_error, clk_i, rst_ni,
                   out_valid_q, !(out_q.write_enable && out_q.factor_error))

endmodule

// ===== rtl/core/pixel_replicating_upscaler.sv =====
// Pixel replicating upscaler: one source pixel becomes a block of framebuffer writes.
// Timing: an accepted pixel passes ST_BASE_MUL, ST_BASE, then ST_EMIT registers its
//   results, one per cycle while the result register is free, via the shared address
//   adder walking the block, or ST_SINGLE one result; a new pixel waits for ST_IDLE.
// Reset: config returns to 320x200, factor 2x2, no gaps; source position to origin.
// Depends on pru_pkg, pru_if, pru_cfg_regs, pru_arith and pru_seq.
module pixel_replicating_upscaler #(
  parameter int MAX_SRC_WIDTH  = 1024,
  parameter int MAX_SRC_HEIGHT = 1024,
  parameter int MAX_FACTOR     = 8,
  parameter int PIXEL_BITS     = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pru_cfg_if.sink   cfg_i,
  pru_in_if.sink    src_i,
  pru_out_if.source res_o
);
  import pru_pkg::*;

  // Factor width covers the largest factor, including the saturation value.
  localparam int F_BITS = $clog2(MAX_FACTOR + 1);

  cfg_raw_t             cfg_raw;
  logic                 mul_en;
  logic [ADDR_BITS-1:0] mul_a;
  logic [F_BITS-1:0]    mul_b;
  logic [ADDR_BITS-1:0] add_a, add_b, prod, sum;

  // Register file: user must write only between transactions so values are stable per pixel (unchecked).
  pru_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg_raw)
  );

  // Shared unit: the multiplier forms pitch, column offset and row step in the
  // setup cycles; the adder forms the block origin, every write address and
  // the next block-row base.
  pru_arith #(
    .FACT_BITS (F_BITS)
  ) u_arith (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .mul_a_i  (mul_a),
    .mul_b_i  (mul_b),
    .add_a_i  (add_a),
    .add_b_i  (add_b),
    .prod_o   (prod),
    .sum_o    (sum)
  );

  // Sequencer: accept a pixel, set up the block origin, emit one result per
  // cycle into the output register when free, then advance the source position.
  pru_seq #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_FACTOR     (MAX_FACTOR),
    .PIXEL_BITS     (PIXEL_BITS),
    .FACT_BITS      (F_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_raw_i (cfg_raw),
    .src_i     (src_i),
    .res_o     (res_o),
    .mul_en_o  (mul_en),
    .mul_a_o   (mul_a),
    .mul_b_o   (mul_b),
    .add_a_o   (add_a),
    .add_b_o   (add_b),
    .prod_i    (prod),
    .sum_i     (sum)
  );

endmodule

// ===== bench/pixel_replicating_upscaler_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pixel_replicating_upscaler: a directed table, then random phases.
// Depends on pru_pkg, the pru_if channel interfaces and the upscaler RTL.
module pixel_replicating_upscaler_tb;
  import pru_pkg::*;

  // Block geometry limits, matching the default parameters of u_top.
  localparam int MAX_W    = 1024;
  localparam int MAX_H    = 1024;
  localparam int MAX_FAC  = 8;
  localparam int PIX_BITS = 32;

  // Run shape.
  localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction on any channel
  localparam int SETTLE_CYCLES = 16;    // extra wait at the end for stray results
  localparam int RAND_PHASES   = 6;
  localparam int PHASE_PIXELS  = 22;
  localparam int MAX_REPORTS   = 10;

  // Register index outside the register map; a write there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  // Single results whose value is plain from the spec.
  localparam out_item_t FACTOR_ERR_RES = '{dest_address: '0, pixel_out: '0,
                                           write_enable: 1'b0, factor_error: 1'b1,
                                           last_write: 1'b1};
  localparam out_item_t GAP_SKIP_RES   = '{dest_address: '0, pixel_out: '0,
                                           write_enable: 1'b0, factor_error: 1'b0,
                                           last_write: 1'b1};
  localparam out_item_t NO_TYPED       = '0;

  typedef enum logic [1:0] {
    ROW_REG,        // register write
    ROW_PIX,        // pixel, results from the block model
    ROW_PIX_TYPED   // pixel, single result given in the row
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    logic [PIX_PORT_BITS-1:0] pixel;
    out_item_t                typed_res;
  } dir_row_t;

  localparam int N_DIR = 42;

  // Directed table: walk the reset setting, both factor error forms, the
  // saturated 8x8 block, gaps that trim and gaps that cover the block, zero and
  // oversize frame sizes, a column left above a lowered width, out-of-range
  // bits on narrow registers and a write to an unmapped index.
  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'hFFFF_FFFF, NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h0000_0000, NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h1234_5678, NO_TYPED},
    '{ROW_REG,       REG_H_FACTOR,   11'd1,     32'h0,         NO_TYPED},
    '{ROW_REG,       REG_V_FACTOR,   11'd1,     32'h0,         NO_TYPED},
    '{ROW_PIX_TYPED, REG_SRC_WIDTH,  11'd0,     32'hA5A5_5A5A, FACTOR_ERR_RES},
    '{ROW_REG,       REG_H_FACTOR,   11'd0,     32'h0,         NO_TYPED},
    '{ROW_REG,       REG_V_FACTOR,   11'd0,     32'h0,         NO_TYPED},
    '{ROW_PIX_TYPED, REG_SRC_WIDTH,  11'd0,     32'hFFFF_FFFF, FACTOR_ERR_RES},
    '{ROW_REG,       REG_H_FACTOR,   11'd15,    32'h0,         NO_TYPED},
    '{ROW_REG,       REG_V_FACTOR,   11'd9,     32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h5A5A_A5A5, NO_TYPED},
    '{ROW_REG,       REG_H_GAP,      11'd7,     32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h0000_FFFF, NO_TYPED},
    '{ROW_REG,       REG_V_GAP,      11'd7,     32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'hFFFF_0000, NO_TYPED},
    '{ROW_REG,       REG_H_FACTOR,   11'd7,     32'h0,         NO_TYPED},
    '{ROW_PIX_TYPED, REG_SRC_WIDTH,  11'd0,     32'h8000_0001, GAP_SKIP_RES},
    '{ROW_REG,       REG_H_FACTOR,   11'd3,     32'h0,         NO_TYPED},
    '{ROW_REG,       REG_H_GAP,      11'd0,     32'h0,         NO_TYPED},
    '{ROW_REG,       REG_V_FACTOR,   11'd3,     32'h0,         NO_TYPED},
    '{ROW_PIX_TYPED, REG_SRC_WIDTH,  11'd0,     32'h7FFF_FFFE, GAP_SKIP_RES},
    '{ROW_REG,       REG_V_GAP,      11'd1,     32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'hC3C3_C3C3, NO_TYPED},
    '{ROW_REG,       REG_SRC_WIDTH,  11'd0,     32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h3C3C_3C3C, NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h0F0F_0F0F, NO_TYPED},
    '{ROW_REG,       REG_SRC_HEIGHT, 11'd1,     32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'hF0F0_F0F0, NO_TYPED},
    '{ROW_REG,       REG_SRC_WIDTH,  11'd2047,  32'h0,         NO_TYPED},
    '{ROW_REG,       REG_SRC_HEIGHT, 11'd2047,  32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h5555_5555, NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'hAAAA_AAAA, NO_TYPED},
    '{ROW_REG,       REG_SRC_WIDTH,  11'd1024,  32'h0,         NO_TYPED},
    '{ROW_REG,       REG_SRC_HEIGHT, 11'd1024,  32'h0,         NO_TYPED},
    '{ROW_REG,       REG_H_FACTOR,   11'h7F2,   32'h0,         NO_TYPED},
    '{ROW_REG,       REG_V_FACTOR,   11'h7F1,   32'h0,         NO_TYPED},
    '{ROW_REG,       REG_H_GAP,      11'h7F9,   32'h0,         NO_TYPED},
    '{ROW_REG,       REG_V_GAP,      11'h7F8,   32'h0,         NO_TYPED},
    '{ROW_REG,       REG_UNUSED,     11'h7FF,   32'h0,         NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h0000_0001, NO_TYPED},
    '{ROW_PIX,       REG_SRC_WIDTH,  11'd0,     32'h8000_0000, NO_TYPED}
  };

  logic clk_i;
  logic rst_ni;

  pru_cfg_if cfg_if ();
  pru_in_if  src_if ();
  pru_out_if res_if ();

  pixel_replicating_upscaler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .src_i  (src_if),
    .res_o  (res_if)
  );

  // Shadow of the register file and the source raster position.
  cfg_raw_t             scale_cfg;
  int unsigned          cur_col;
  int unsigned          cur_row;
  logic [ADDR_BITS-1:0] line_origin;

  out_item_t block_writes[$];    // results for the pixel just predicted
  out_item_t pending_writes[$];  // results still owed by the block, oldest first

  int  error_count;
  int  quiet_cycles;
  int  stall_left;
  bit  src_idle;
  bit  sink_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Zero size counts as one, oversize saturates.
  function automatic int unsigned sat_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Mirror a register write into the shadow copy; the write width of each
  // register drops the upper data bits.
  function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_SRC_WIDTH:  scale_cfg.src_width  = data;
      REG_SRC_HEIGHT: scale_cfg.src_height = data;
      REG_H_FACTOR:   scale_cfg.h_factor   = data[3:0];
      REG_V_FACTOR:   scale_cfg.v_factor   = data[3:0];
      REG_H_GAP:      scale_cfg.h_gap      = data[2:0];
      REG_V_GAP:      scale_cfg.v_gap      = data[2:0];
      default: ;
    endcase
  endfunction

  // Fill block_writes with the framebuffer writes of one source pixel and
  // advance the raster position. Column offset is the outer loop, row the inner.
  function automatic void replicate_pixel(input logic [PIX_PORT_BITS-1:0] pix);
    int unsigned          w, h, hf, vf, pitch, cols, rows, total, n;
    logic [ADDR_BITS-1:0] origin;
    out_item_t            wr;
    w     = sat_dim(scale_cfg.src_width, MAX_W);
    h     = sat_dim(scale_cfg.src_height, MAX_H);
    hf    = sat_dim(scale_cfg.h_factor, MAX_FAC);
    vf    = sat_dim(scale_cfg.v_factor, MAX_FAC);
    pitch = w * hf;
    n     = 0;
    block_writes.delete();
    if (hf == 1 && vf == 1) begin
      block_writes.push_back(FACTOR_ERR_RES);
    end else if (scale_cfg.h_gap >= hf || scale_cfg.v_gap >= vf) begin
      block_writes.push_back(GAP_SKIP_RES);
    end else begin
      cols  = hf - scale_cfg.h_gap;
      rows  = vf - scale_cfg.v_gap;
      total = cols * rows;
      if (total > MAX_RESULTS) total = MAX_RESULTS;
      origin = ADDR_BITS'(line_origin + cur_col * hf);
      for (int unsigned k = 0; k < cols; k++) begin
        for (int unsigned l = 0; l < rows; l++) begin
          if (n < total) begin
            wr.dest_address = ADDR_BITS'(origin + k + pitch * l);
            wr.pixel_out    = pix & ({PIX_PORT_BITS{1'b1}} >> (PIX_PORT_BITS - PIX_BITS));
            wr.write_enable = 1'b1;
            wr.factor_error = 1'b0;
            wr.last_write   = (n + 1 == total);
            block_writes.push_back(wr);
            n++;
          end
        end
      end
    end
    // Wrap checks are "at or above" so a column left past a lowered width wraps now.
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      line_origin = ADDR_BITS'(line_origin + pitch * vf);
      if (cur_row >= h) begin
        cur_row     = 0;
        line_origin = '0;
      end
    end
  endfunction

  // Write one register. Wait until the block owes nothing, so the new value
  // cannot touch a pixel still in flight. Leave cfg valid high on return so
  // back-to-back writes follow without dropping valid.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    bit took;
    src_if.valid <= 1'b0;
    while (pending_writes.size() != 0) begin
      cfg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cfg_if.valid         <= 1'b1;
    cfg_if.payload.index <= idx;
    cfg_if.payload.data  <= data;
    // Sample the handshake at the falling edge: inputs only move at rising
    // edges, so this is what the next rising edge will see.
    do begin
      @(negedge clk_i);
      took = cfg_if.ready;
      @(posedge clk_i);
    end while (!took);
    apply_reg(idx, data);
  endtask

  // Send one pixel, with an optional idle burst first, and queue what it must
  // produce. A typed row queues its given result; the model still runs so the
  // raster position keeps in step.
  task automatic feed_pixel(input logic [PIX_PORT_BITS-1:0] pix, input bit use_typed,
                            input out_item_t typed_res);
    bit took;
    cfg_if.valid <= 1'b0;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      src_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    src_if.valid             <= 1'b1;
    src_if.payload.src_pixel <= pix;
    do begin
      @(negedge clk_i);
      took = src_if.ready;
      @(posedge clk_i);
    end while (!took);
    replicate_pixel(pix);
    if (use_typed) begin
      pending_writes.push_back(typed_res);
    end else begin
      foreach (block_writes[i]) pending_writes.push_back(block_writes[i]);
    end
  endtask

  // Frame sizes: mostly tiny so rows and frames wrap often, now and then zero,
  // the maximum or an oversize value.
  function automatic logic [CFG_DATA_BITS-1:0] rand_size(input int unsigned top);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_BITS'($urandom_range(MAX_W + 1, 2047));
      2:       return CFG_DATA_BITS'(MAX_W);
      default: return CFG_DATA_BITS'($urandom_range(1, top));
    endcase
  endfunction

  // Result channel: stall ready in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Check every result transaction against the oldest expected one, and run
  // the watchdog on cycles with no transaction on any channel.
  always @(negedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    string     diffs;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got = res_if.payload;
        if (pending_writes.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: addr=%h pix=%h we=%b err=%b last=%b",
                     got.dest_address, got.pixel_out, got.write_enable,
                     got.factor_error, got.last_write);
        end else begin
          want  = pending_writes.pop_front();
          diffs = "";
          if (got.dest_address !== want.dest_address) diffs = {diffs, " dest_address"};
          if (got.pixel_out    !== want.pixel_out)    diffs = {diffs, " pixel_out"};
          if (got.write_enable !== want.write_enable) diffs = {diffs, " write_enable"};
          if (got.factor_error !== want.factor_error) diffs = {diffs, " factor_error"};
          if (got.last_write   !== want.last_write)   diffs = {diffs, " last_write"};
          if (diffs != "") begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch in%s", diffs);
              $display("  expected addr=%h pix=%h we=%b err=%b last=%b",
                       want.dest_address, want.pixel_out, want.write_enable,
                       want.factor_error, want.last_write);
              $display("  actual   addr=%h pix=%h we=%b err=%b last=%b",
                       got.dest_address, got.pixel_out, got.write_enable,
                       got.factor_error, got.last_write);
            end
          end
        end
      end
      if ((src_if.valid && src_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    // Drive every input to a known value before the first edge; the result
    // ready is owned by the sink process above.
    rst_ni         <= 1'b0;
    src_if.valid   <= 1'b0;
    src_if.payload <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    error_count  = 0;
    quiet_cycles = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    // Register reset values: 320x200 source, 2x2 blocks, no gaps.
    scale_cfg   = '{src_width: 11'd320, src_height: 11'd200, h_factor: 4'd2,
                    v_factor: 4'd2, h_gap: 3'd0, v_gap: 3'd0};
    cur_col     = 0;
    cur_row     = 0;
    line_origin = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table first.
    foreach (DIR_TABLE[i]) begin
      case (DIR_TABLE[i].kind)
        ROW_REG:       write_reg(DIR_TABLE[i].idx, DIR_TABLE[i].data);
        ROW_PIX:       feed_pixel(DIR_TABLE[i].pixel, 1'b0, NO_TYPED);
        ROW_PIX_TYPED: feed_pixel(DIR_TABLE[i].pixel, 1'b1, DIR_TABLE[i].typed_res);
        default: ;
      endcase
    end

    // Random phases: a fresh setting of every register, then a run of pixels.
    // One middle phase and the last phase run without idling.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      src_idle  = (ph != 2) && (ph != RAND_PHASES - 1);
      sink_idle = src_idle;
      write_reg(REG_SRC_WIDTH,  rand_size(6));
      write_reg(REG_SRC_HEIGHT, rand_size(4));
      write_reg(REG_H_FACTOR,   CFG_DATA_BITS'($urandom_range(0, 2047)));
      write_reg(REG_V_FACTOR,   CFG_DATA_BITS'($urandom_range(0, 2047)));
      write_reg(REG_H_GAP,
                CFG_DATA_BITS'($urandom_range(0, 1) ? $urandom_range(0, 2047) : 0));
      write_reg(REG_V_GAP,
                CFG_DATA_BITS'($urandom_range(0, 1) ? $urandom_range(0, 2047) : 0));
      repeat (PHASE_PIXELS) feed_pixel($urandom, 1'b0, NO_TYPED);
    end

    // Drain, then hold a little longer to catch results nobody asked for.
    src_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
